>>> rtl/lwbr_pkg.sv
// Shared types and constants for the longest-window-with-bounded-repeats core.
// Used by every module of the block except lwbr_ram; depends on nothing else.

package lwbr_pkg;

    // Storage sizes. ALPHABET_SIZE and QUEUE_DEPTH must be powers of two.
    localparam int WINDOW_DEPTH  = 4096;
    localparam int ALPHABET_SIZE = 256;
    localparam int QUEUE_DEPTH   = 2;

    // Field widths of the stream items and the limit register.
    localparam int SYM_W       = 8;
    localparam int LEN_W       = 12;
    localparam int LIM_W       = 4;
    localparam int CNT_W       = LIM_W;
    localparam int LIMIT_RESET = 2;

    // Derived widths.
    localparam int WIN_AW      = $clog2(WINDOW_DEPTH);
    localparam int SYM_IDX_W   = $clog2(ALPHABET_SIZE);
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int IN_TDATA_W  = ((SYM_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((2 * LEN_W + 7) / 8) * 8;

    // The window never holds more than this many symbols.
    localparam int LEN_MAX = (1 << LEN_W) - 1;
    localparam int WIN_CAP = (WINDOW_DEPTH - 1 > LEN_MAX) ? LEN_MAX : WINDOW_DEPTH - 1;

    // One classified input item as it waits in the queue.
    typedef struct packed {
        logic                 last;
        logic [SYM_IDX_W-1:0] sym;
    } lwbr_item_t;

    // One result item.
    typedef struct packed {
        logic             string_done;
        logic [LEN_W-1:0] best_length;
        logic [LEN_W-1:0] window_length;
    } lwbr_result_t;

    // Status of the back part, watched by the top level.
    typedef struct packed {
        logic              busy;
        logic [WIN_AW-1:0] win_len;
    } lwbr_status_t;

    // Sequencer states of the back part.
    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_LOAD   = 5'b00010,
        ST_DECIDE = 5'b00100,
        ST_EVRD   = 5'b01000,
        ST_EVCNT  = 5'b10000
    } lwbr_state_t;

endpackage

>>> rtl/longest_window_bounded_repeats_core.sv
// Top level of the longest-window-with-bounded-repeats core.
// Depends on lwbr_pkg, lwbr_front and lwbr_back.

// For every symbol of a string the core returns one transfer with the length of the
// longest window ending at that symbol in which no symbol occurs more than the limit
// (cfg_wdata, reset value 2, zero acts as one), and the best such length so far; tlast
// on the input ends the string and comes back as tlast on the result, after which the
// string state is empty again. Each symbol passes the back sequencer states IDLE, LOAD and
// DECIDE, plus EVRD, EVCNT and DECIDE again for every symbol the window drops from its
// left edge on its way: the registered read of the window memory, the registered read and
// write-back of the dropped symbol's count, and a fresh decision. Both memories have one read
// port and one write port, each with a registered read.
// Each symbol leaves the window at most once. A two-entry queue lets inputs arrive while
// the sequencer works, and the result register lets the next symbol start while a result
// waits. Counts clear at once through per-symbol valid bits, so there is no clearing pass
// after reset.

module longest_window_bounded_repeats_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lwbr_pkg::IN_TDATA_W-1:0]  s_tdata,   // [7:0] symbol
    input  logic                            s_tlast,   // last_symbol
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lwbr_pkg::OUT_TDATA_W-1:0] m_tdata,  // [11:0] window_length, [23:12] best_length
    output logic                            m_tlast,   // string_done
    input  logic                            cfg_we,
    input  logic [lwbr_pkg::LIM_W-1:0]      cfg_wdata  // max_occurrences
);

    import lwbr_pkg::*;

    logic [LIM_W-1:0] limit;
    lwbr_item_t       item;
    logic             item_valid;
    logic             item_pop;
    lwbr_result_t     result;
    lwbr_status_t     status;

    // Accept transfers and queue classified items.
    lwbr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .limit      (limit),
        .item       (item),
        .item_valid (item_valid),
        .item_pop   (item_pop)
    );

    // Walk the window and produce results.
    lwbr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .limit      (limit),
        .item       (item),
        .item_valid (item_valid),
        .item_pop   (item_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .result     (result),
        .status     (status)
    );

    // Pack the result onto the output stream.
    assign m_tdata = OUT_TDATA_W'({result.best_length, result.window_length});
    assign m_tlast = result.string_done;

    // A reported window is never empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[LEN_W-1:0] != '0))
        else $error("empty window reported");

    // The best length never falls below the current window length.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[LEN_W-1:0] <= m_tdata[2*LEN_W-1:LEN_W]))
        else $error("best length below window length");

    // The window stays within its capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        status.win_len <= WIN_AW'(WIN_CAP))
        else $error("window exceeds capacity");

    // The queue is drained only by the sequencer when it is idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_pop |=> status.busy)
        else $error("sequencer did not start on popped item");

endmodule

>>> rtl/lwbr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; no package is needed.

module lwbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/lwbr_front.sv
// Front part: limit register, input acceptance and the short item queue.
// Depends on lwbr_pkg.

module lwbr_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [lwbr_pkg::IN_TDATA_W-1:0] s_tdata,   // [7:0] symbol
    input  logic                           s_tlast,   // last_symbol
    input  logic                           cfg_we,
    input  logic [lwbr_pkg::LIM_W-1:0]     cfg_wdata,
    output logic [lwbr_pkg::LIM_W-1:0]     limit,
    output lwbr_pkg::lwbr_item_t           item,
    output logic                           item_valid,
    input  logic                           item_pop
);

    import lwbr_pkg::*;

    logic [LIM_W-1:0]    limit_reg;
    lwbr_item_t          q_mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;
    logic [QUEUE_AW:0]   count_next;
    logic                push;
    lwbr_item_t          in_item;

    // The limit register; a written zero acts as one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIM_W'(LIMIT_RESET);
        end
        else if (cfg_we)
        begin
            limit_reg <= cfg_wdata;
        end
    end

    assign limit = (limit_reg == '0) ? LIM_W'(1) : limit_reg;

    // Classify the incoming transfer: fold the symbol into the alphabet.
    assign in_item.sym  = s_tdata[SYM_IDX_W-1:0];
    assign in_item.last = s_tlast;

    assign s_tready   = (count_reg != (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign push       = s_tvalid && s_tready;
    assign item_valid = (count_reg != '0);
    assign item       = q_mem_reg[rd_ptr_reg];

    // Fill level of the queue.
    always_comb
    begin
        count_next = count_reg;
        if (push && !item_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && item_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Queue pointers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (item_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Queue entries.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

>>> rtl/lwbr_back.sv
// Back part: window sequencer with the count and window memories and the result register.
// Depends on lwbr_pkg and lwbr_ram.

module lwbr_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [lwbr_pkg::LIM_W-1:0] limit,
    input  lwbr_pkg::lwbr_item_t       item,
    input  logic                       item_valid,
    output logic                       item_pop,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output lwbr_pkg::lwbr_result_t     result,
    output lwbr_pkg::lwbr_status_t     status
);

    import lwbr_pkg::*;

    lwbr_state_t          state_reg;
    lwbr_state_t          state_next;
    logic [SYM_IDX_W-1:0] sym_reg;
    logic                 last_reg;
    logic [CNT_W-1:0]     sym_cnt_reg;
    logic [SYM_IDX_W-1:0] ev_sym_reg;
    logic [WIN_AW-1:0]    left_ptr_reg;
    logic [WIN_AW-1:0]    right_ptr_reg;
    logic [LEN_W-1:0]     best_reg;
    logic [ALPHABET_SIZE-1:0] cnt_vld_reg;
    logic                 cnt_vld_rd_reg;
    logic                 out_valid_reg;
    lwbr_result_t         out_reg;

    logic [WIN_AW-1:0]    win_len;
    logic [WIN_AW-1:0]    new_len;
    logic [LEN_W-1:0]     new_len_out;
    logic [LEN_W-1:0]     new_best;
    logic                 evict_cond;
    logic                 out_free;
    logic                 commit;
    logic [CNT_W-1:0]     cnt_rd_val;

    logic                 cnt_we;
    logic [SYM_IDX_W-1:0] cnt_waddr;
    logic [CNT_W-1:0]     cnt_wdata;
    logic [SYM_IDX_W-1:0] cnt_raddr;
    logic [CNT_W-1:0]     cnt_rdata;
    logic                 win_we;
    logic [SYM_IDX_W-1:0] win_rdata;

    // Per-symbol occurrence counts; an entry without its valid bit reads as zero.
    lwbr_ram #(
        .WIDTH (CNT_W),
        .DEPTH (ALPHABET_SIZE)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    // Ring buffer of the symbols inside the window.
    lwbr_ram #(
        .WIDTH (SYM_IDX_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_win_ram (
        .clk   (clk),
        .we    (win_we),
        .waddr (right_ptr_reg),
        .wdata (sym_reg),
        .raddr (left_ptr_reg),
        .rdata (win_rdata)
    );

    // Window arithmetic and the eviction decision.
    assign win_len     = right_ptr_reg - left_ptr_reg;
    assign new_len     = win_len + 1'b1;
    assign new_len_out = LEN_W'(new_len);
    assign new_best    = (new_len_out > best_reg) ? new_len_out : best_reg;
    assign evict_cond  = (win_len >= WIN_AW'(WIN_CAP)) ||
                         ((sym_cnt_reg >= limit) && (win_len != '0));
    assign out_free    = !out_valid_reg || m_tready;
    assign commit      = (state_reg == ST_DECIDE) && !evict_cond && out_free;
    assign cnt_rd_val  = cnt_vld_rd_reg ? cnt_rdata : '0;
    assign item_pop    = (state_reg == ST_IDLE) && item_valid;
    assign win_we      = commit;

    // Count memory ports: read the new symbol on pop, the evicted symbol after
    // the window read; write on eviction and on commit.
    always_comb
    begin
        cnt_raddr = win_rdata;
        cnt_we    = 1'b0;
        cnt_waddr = sym_reg;
        cnt_wdata = sym_cnt_reg + 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_raddr = item.sym;
            end
            ST_DECIDE:
            begin
                cnt_we = commit;
            end
            ST_EVCNT:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = ev_sym_reg;
                cnt_wdata = (cnt_rd_val != '0) ? cnt_rd_val - 1'b1 : '0;
            end
            default:
            begin
                cnt_raddr = win_rdata;
            end
        endcase
    end

    // Sequencer transitions.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (evict_cond)
                begin
                    state_next = ST_EVRD;
                end
                else if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EVRD:
            begin
                state_next = ST_EVCNT;
            end
            ST_EVCNT:
            begin
                state_next = ST_DECIDE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state: sequencer, pointers, best length, valid bits, result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            left_ptr_reg   <= '0;
            right_ptr_reg  <= '0;
            best_reg       <= '0;
            cnt_vld_reg    <= '0;
            cnt_vld_rd_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_vld_rd_reg <= cnt_vld_reg[cnt_raddr];
            if (state_reg == ST_EVCNT)
            begin
                left_ptr_reg <= left_ptr_reg + 1'b1;
            end
            if (commit && last_reg)
            begin
                // End of string: drop all counts, pointers and the best length.
                left_ptr_reg  <= '0;
                right_ptr_reg <= '0;
                best_reg      <= '0;
                cnt_vld_reg   <= '0;
            end
            else
            begin
                if (commit)
                begin
                    right_ptr_reg <= right_ptr_reg + 1'b1;
                    best_reg      <= new_best;
                end
                if (cnt_we)
                begin
                    cnt_vld_reg[cnt_waddr] <= 1'b1;
                end
            end
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working item, running count of its symbol, and the result payload.
    always_ff @(posedge clk)
    begin
        if (item_pop)
        begin
            sym_reg  <= item.sym;
            last_reg <= item.last;
        end
        if (state_reg == ST_LOAD)
        begin
            sym_cnt_reg <= cnt_rd_val;
        end
        else if (state_reg == ST_EVCNT && ev_sym_reg == sym_reg && sym_cnt_reg != '0)
        begin
            sym_cnt_reg <= sym_cnt_reg - 1'b1;
        end
        if (state_reg == ST_EVRD)
        begin
            ev_sym_reg <= win_rdata;
        end
        if (commit)
        begin
            out_reg.window_length <= new_len_out;
            out_reg.best_length   <= new_best;
            out_reg.string_done   <= last_reg;
        end
    end

    assign m_tvalid       = out_valid_reg;
    assign result         = out_reg;
    assign status.busy    = (state_reg != ST_IDLE);
    assign status.win_len = win_len;

endmodule
